/* rtl/core/vmkcr_pkg.sv */
// Package for the validated multi-key candidate ranker.
// Holds request/result structs, opcodes, error codes and controller states.
// No dependencies.
package vmkcr_pkg;

  localparam int unsigned KeyW = 48;
  localparam int unsigned UtilW = 17;
  localparam int unsigned TileW = 24;
  localparam logic [UtilW-1:0] UtilOne = 17'd65536;

  typedef enum logic [1:0] {
    OP_LEGAL   = 2'd0,
    OP_ILLEGAL = 2'd1,
    OP_COST    = 2'd2,
    OP_FINISH  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NO_LEGAL  = 3'd1,
    ERR_UNKNOWN   = 3'd2,
    ERR_ILLEGAL   = 3'd3,
    ERR_DUPLICATE = 3'd4,
    ERR_INVALID   = 3'd5,
    ERR_MISSING   = 3'd6,
    ERR_OVERFLOW  = 3'd7
  } err_e;

  localparam logic [3:0] KeyIndex = 4'd7;
  localparam logic [3:0] KeyNone  = 4'd8;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       cand_index;
    logic [KeyW-1:0]  est_total_cycles;
    logic [KeyW-1:0]  off_chip_bytes;
    logic [KeyW-1:0]  dma_cycle_count;
    logic [KeyW-1:0]  local_mem_cycles;
    logic [KeyW-1:0]  compute_cycle_count;
    logic [KeyW-1:0]  physical_mac_count;
    logic [UtilW-1:0] pe_util;
    logic [TileW-1:0] tile_total;
    logic [TileW-1:0] tiles_m;
    logic [TileW-1:0] tiles_n;
  } req_t;

  typedef struct packed {
    logic [2:0]      error_code;
    logic [3:0]      rank;
    logic [3:0]      original_index;
    logic [KeyW-1:0] ranked_total_cycles;
    logic            is_selected;
    logic            is_last;
    logic [4:0]      legal_total;
    logic [4:0]      illegal_total;
    logic            has_runner_up;
    logic [KeyW-1:0] cycle_advantage;
    logic            primary_tied;
    logic [3:0]      decisive_key;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_SUMM,
    ST_EMIT,
    ST_CLEAR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture accepted request
    logic apply;     // apply a record, estimate or finish
    logic scan_init; // start the rank scan
    logic cmp_step;  // one compare in the rank scan
    logic summ;      // latch winner/runner-up summary
    logic emit;      // drive one result
    logic clear;     // clear counts, flags and latched error
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_finish;
    logic has_error;
    logic scan_done;
    logic emit_last;
  } sts_t;

endpackage

/* rtl/core/vmkcr_ctrl.sv */
// Controller state machine of the candidate ranker.
// Depends on vmkcr_pkg.
module vmkcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  vmkcr_pkg::sts_t  sts_i,
  output vmkcr_pkg::cmd_t  cmd_o
);
  import vmkcr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SCAN;
      ST_SCAN: begin
        if (!sts_i.is_finish)     state_d = ST_IDLE;
        else if (sts_i.has_error) state_d = ST_EMIT;
        else                      state_d = ST_CMP;
      end
      ST_CMP:  if (sts_i.scan_done) state_d = ST_SUMM;
      ST_SUMM: state_d = ST_EMIT;
      ST_EMIT: if (sts_i.emit_last) state_d = ST_CLEAR;
      ST_CLEAR: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:  cmd_o.load = start_i;
      ST_SCAN:  begin
        cmd_o.apply = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      // no compare once the last pair is done
      ST_CMP:   cmd_o.cmp_step = !sts_i.scan_done;
      ST_SUMM:  cmd_o.summ = 1'b1;
      ST_EMIT:  cmd_o.emit = 1'b1;
      ST_CLEAR: cmd_o.clear = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_from_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> busy_o) else $error("emit while idle");
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> $past(cmd_o.emit)) else $error("clear without emit");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o) else $error("load while busy");
`endif
endmodule

/* rtl/core/vmkcr_datapath.sv */
// Datapath of the candidate ranker: flags, key registers, rank counters,
// error latching and result formation. Depends on vmkcr_pkg.
module vmkcr_datapath #(
  parameter int unsigned MAX_CANDIDATES = 16,
  parameter int unsigned COST_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vmkcr_pkg::req_t req_i,
  input  vmkcr_pkg::cmd_t cmd_i,
  output vmkcr_pkg::sts_t sts_o,
  output logic            res_valid_o,
  output vmkcr_pkg::res_t res_o
);
  import vmkcr_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CANDIDATES);
  localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned KW = (COST_BITS < KeyW) ? COST_BITS : KeyW;
  localparam int unsigned RW = 6 * KW + UtilW;

  typedef logic [RW-1:0] rec_t;

  req_t req_q;
  logic [CW-1:0] count_q, count_d;
  logic [MAX_CANDIDATES-1:0] legal_q, seen_q;
  logic [2:0] ferr_q;
  rec_t keys_q [MAX_CANDIDATES];
  logic [CW-1:0] legal_cnt, illegal_cnt;

  // rank scan: rank of each entry = number of legal entries better than it
  logic [IW-1:0] ia_q, ib_q;
  logic [CW-1:0] rank_q [MAX_CANDIDATES];
  logic done_q;
  logic [2:0] err_q;
  logic [CW-1:0] er_q;

  function automatic logic [KW-1:0] key_of(rec_t r, int k);
    return r[RW-1-k*KW -: KW];
  endfunction

  function automatic logic [3:0] first_diff(rec_t a, rec_t b);
    logic [3:0] d;
    d = KeyIndex;
    if (a[UtilW-1:0] != b[UtilW-1:0]) d = 4'd6;
    for (int k = 5; k >= 0; k--)
      if (key_of(a, k) != key_of(b, k)) d = 4'(k);
    return d;
  endfunction

  function automatic logic better(rec_t a, rec_t b, logic [IW-1:0] ai, logic [IW-1:0] bi);
    logic [3:0] d;
    logic res;
    d = first_diff(a, b);
    if (d == 4'd6)            res = a[UtilW-1:0] > b[UtilW-1:0];
    else if (d == KeyIndex)   res = ai < bi;
    else                      res = key_of(a, int'(d)) < key_of(b, int'(d));
    return res;
  endfunction

  always_comb begin
    legal_cnt = '0;
    illegal_cnt = '0;
    for (int i = 0; i < MAX_CANDIDATES; i++) begin
      if (CW'(i) < count_q) begin
        if (legal_q[i]) legal_cnt = legal_cnt + 1'b1;
        else            illegal_cnt = illegal_cnt + 1'b1;
      end
    end
  end

  logic cost_ok;
  logic [2:0] cost_err;
  logic [IW-1:0] cidx;
  assign cidx = req_q.cand_index[IW-1:0];
  always_comb begin
    cost_err = ERR_OK;
    if ({24'd0, req_q.cand_index} >= 32'(count_q)) cost_err = ERR_UNKNOWN;
    else if (!legal_q[cidx])                       cost_err = ERR_ILLEGAL;
    else if (seen_q[cidx])                         cost_err = ERR_DUPLICATE;
    else if (req_q.pe_util > UtilOne)              cost_err = ERR_INVALID;
    else if (req_q.tile_total == '0 || req_q.tiles_m == '0 || req_q.tiles_n == '0
             || req_q.compute_cycle_count == '0) cost_err = ERR_INVALID;
    cost_ok = (cost_err == ERR_OK);
  end

  logic [2:0] fin_err;
  always_comb begin
    fin_err = ERR_OK;
    if (ferr_q == ERR_OVERFLOW)  fin_err = ERR_OVERFLOW;
    else if (legal_cnt == '0)    fin_err = ERR_NO_LEGAL;
    else if (ferr_q != ERR_OK)   fin_err = ferr_q;
    else if ((legal_q & ~seen_q) != '0) fin_err = ERR_MISSING;
  end

  logic b_better;
  assign b_better = better(keys_q[ib_q], keys_q[ia_q], ib_q, ia_q);

  assign count_d = count_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.apply && req_q.opcode == OP_COST && ferr_q == ERR_OK && cost_ok)
      keys_q[cidx] <= {req_q.est_total_cycles[KW-1:0], req_q.off_chip_bytes[KW-1:0],
                       req_q.dma_cycle_count[KW-1:0], req_q.local_mem_cycles[KW-1:0],
                       req_q.compute_cycle_count[KW-1:0],
                       req_q.physical_mac_count[KW-1:0], req_q.pe_util};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      legal_q <= '0;
      seen_q <= '0;
      ferr_q <= ERR_OK;
      ia_q <= '0;
      ib_q <= '0;
      done_q <= 1'b0;
      err_q <= ERR_OK;
      er_q <= '0;
      for (int i = 0; i < MAX_CANDIDATES; i++) rank_q[i] <= '0;
    end else begin
      if (cmd_i.apply) begin
        unique case (req_q.opcode)
          OP_LEGAL, OP_ILLEGAL: begin
            if (count_q >= CW'(MAX_CANDIDATES)) begin
              if (ferr_q == ERR_OK) ferr_q <= ERR_OVERFLOW;
            end else begin
              legal_q[count_q[IW-1:0]] <= (req_q.opcode == OP_LEGAL);
              count_q <= count_d;
            end
          end
          OP_COST: if (ferr_q == ERR_OK) begin
            if (cost_ok) seen_q[cidx] <= 1'b1;
            else         ferr_q <= cost_err;
          end
          OP_FINISH: err_q <= fin_err;
          default: ;
        endcase
      end
      if (cmd_i.scan_init) begin
        ia_q <= '0;
        ib_q <= '0;
        done_q <= 1'b0;
        er_q <= '0;
        for (int i = 0; i < MAX_CANDIDATES; i++) rank_q[i] <= '0;
      end
      // one ordered pair per cycle
      if (cmd_i.cmp_step) begin
        if (legal_q[ia_q] && legal_q[ib_q] && ia_q != ib_q && b_better)
          rank_q[ia_q] <= rank_q[ia_q] + 1'b1;
        if (ib_q == IW'(MAX_CANDIDATES - 1)) begin
          ib_q <= '0;
          if (ia_q == IW'(MAX_CANDIDATES - 1)) done_q <= 1'b1;
          else ia_q <= ia_q + 1'b1;
        end else ib_q <= ib_q + 1'b1;
      end
      if (cmd_i.emit) er_q <= er_q + 1'b1;
      if (cmd_i.clear) begin
        count_q <= '0;
        legal_q <= '0;
        seen_q <= '0;
        ferr_q <= ERR_OK;
      end
    end
  end

  // winner and runner-up found by rank
  logic [IW-1:0] w_idx, r_idx, e_idx;
  always_comb begin
    w_idx = '0;
    r_idx = '0;
    e_idx = '0;
    for (int i = 0; i < MAX_CANDIDATES; i++) begin
      if (legal_q[i] && rank_q[i] == '0) w_idx = IW'(i);
      if (legal_q[i] && rank_q[i] == CW'(1)) r_idx = IW'(i);
      if (legal_q[i] && rank_q[i] == er_q) e_idx = IW'(i);
    end
  end

  logic runner_q, tied_q;
  logic [KW-1:0] adv_q;
  logic [3:0] dkey_q;
  logic [KW-1:0] wk, rk;
  assign wk = key_of(keys_q[w_idx], 0);
  assign rk = key_of(keys_q[r_idx], 0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.summ) begin
      runner_q <= (legal_cnt >= CW'(2));
      tied_q <= (legal_cnt >= CW'(2)) && (rk == wk);
      adv_q <= (legal_cnt >= CW'(2) && rk >= wk) ? rk - wk : '0;
      dkey_q <= (legal_cnt >= CW'(2)) ? first_diff(keys_q[w_idx], keys_q[r_idx]) : KeyNone;
    end
  end

  always_comb begin
    res_o = '0;
    res_o.legal_total = 5'(legal_cnt);
    res_o.illegal_total = 5'(illegal_cnt);
    if (err_q != ERR_OK) begin
      res_o.error_code = err_q;
      res_o.is_last = 1'b1;
    end else begin
      res_o.rank = 4'(er_q);
      res_o.original_index = 4'(e_idx);
      res_o.ranked_total_cycles = KeyW'(key_of(keys_q[e_idx], 0));
      res_o.is_selected = (er_q == '0);
      res_o.is_last = (er_q + 1'b1 == legal_cnt);
      res_o.has_runner_up = runner_q;
      res_o.cycle_advantage = KeyW'(adv_q);
      res_o.primary_tied = tied_q;
      res_o.decisive_key = dkey_q;
    end
  end

  assign res_valid_o = cmd_i.emit;
  assign sts_o.is_finish = (req_q.opcode == OP_FINISH);
  assign sts_o.has_error = (fin_err != ERR_OK);
  assign sts_o.scan_done = done_q;
  assign sts_o.emit_last = res_o.is_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_CANDIDATES)) else $error("candidate count overflow");
  a_seen_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q & ~legal_q) == '0) else $error("estimate on illegal entry");
  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> count_q == '0 && ferr_q == ERR_OK) else $error("clear failed");
`endif
endmodule

/* rtl/core/validated_multi_key_candidate_ranker.sv */
// Top level of the validated multi-key candidate ranker.
// Depends on vmkcr_pkg, vmkcr_ctrl and vmkcr_datapath.
//
// Usage:
//  - Request channel: drive req_i and raise start_i; a request is taken at a
//    clock edge where start_i is high and busy_o is low.
//  - Record and estimate requests are captured, then applied; busy_o is
//    high for the apply cycle.
//  - A finish request checks the latched error. With an error, one result
//    follows the apply step. Otherwise a pairwise rank scan runs, one compare
//    per cycle over MAX_CANDIDATES^2 ordered pairs plus a final step to see the
//    scan end, then a summary step, then one result per legal candidate on
//    consecutive cycles, best first. A clear step follows the last result
//    before busy_o drops. The scan uses a single compare unit.
//  - Results: res_valid_o pulses for one cycle per result; the receiver
//    cannot stall, so nothing is held back.
//  - After the last result, counts, flags and the latched error return to reset.
//  - Reset (rst_ni low, asynchronous) clears counts, flags and the latched
//    error; cost registers are only read after being written.
module validated_multi_key_candidate_ranker #(
  parameter int unsigned MAX_CANDIDATES = 16,
  parameter int unsigned COST_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  vmkcr_pkg::req_t req_i,
  output logic            res_valid_o,
  output vmkcr_pkg::res_t res_o
);
  import vmkcr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vmkcr_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .sts_i(sts), .cmd_o(cmd)
  );

  vmkcr_datapath #(
    .MAX_CANDIDATES(MAX_CANDIDATES), .COST_BITS(COST_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .res_valid_o, .res_o
  );
endmodule

/* bench/validated_multi_key_candidate_ranker_test.sv */
// Testbench for the validated multi-key candidate ranker.
// Self-checking: a local ranking predictor fills a queue of expected results.
// Depends on vmkcr_pkg and validated_multi_key_candidate_ranker.
module validated_multi_key_candidate_ranker_test;
  import vmkcr_pkg::*;

  localparam int unsigned NCand = 16;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [47:0] KeyMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [23:0] TileMax = 24'hFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic res_valid_o;
  res_t res_o;

  always #1 clk_i = ~clk_i;

  validated_multi_key_candidate_ranker u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // ---- predictor state: mirrors the block's candidate table ----
  int unsigned  cand_cnt;
  bit           legal_q [NCand];
  bit           seen_q [NCand];
  err_e         latched_err;
  logic [47:0]  key_q [NCand][6];
  logic [16:0]  util_q [NCand];

  res_t ranking_q[$];   // results still owed by the block
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  function automatic void clear_table();
    cand_cnt = 0;
    latched_err = ERR_OK;
    for (int i = 0; i < NCand; i++) begin
      legal_q[i] = 1'b0;
      seen_q[i] = 1'b0;
    end
  endfunction

  function automatic void latch_err(err_e code);
    if (latched_err == ERR_OK) latched_err = code;
  endfunction

  // first differing key 0..6, 7 when all seven keys match
  function automatic logic [3:0] diff_key(int a, int b);
    for (int k = 0; k < 6; k++)
      if (key_q[a][k] != key_q[b][k]) return 4'(k);
    if (util_q[a] != util_q[b]) return 4'd6;
    return KeyIndex;
  endfunction

  function automatic bit ranks_ahead(int a, int b);
    logic [3:0] k;
    k = diff_key(a, b);
    if (k < 6) return key_q[a][k] < key_q[b][k];
    if (k == 6) return util_q[a] > util_q[b];
    return a < b;
  endfunction

  // apply one accepted request; a finish queues its results
  function automatic void rank_predict(req_t rq);
    int unsigned nleg, nill, n, j;
    int order [NCand];
    err_e code;
    res_t r;
    logic [47:0] w, ru;
    case (opcode_e'(rq.opcode))
      OP_LEGAL, OP_ILLEGAL: begin
        if (cand_cnt >= NCand) latch_err(ERR_OVERFLOW);
        else begin
          legal_q[cand_cnt] = (rq.opcode == OP_LEGAL);
          cand_cnt++;
        end
      end
      OP_COST: begin
        if (latched_err != ERR_OK) return;
        if (rq.cand_index >= cand_cnt) latch_err(ERR_UNKNOWN);
        else if (!legal_q[rq.cand_index]) latch_err(ERR_ILLEGAL);
        else if (seen_q[rq.cand_index]) latch_err(ERR_DUPLICATE);
        else if (rq.pe_util > UtilOne) latch_err(ERR_INVALID);
        else if (rq.tile_total == 0 || rq.tiles_m == 0 || rq.tiles_n == 0 ||
                 rq.compute_cycle_count == 0) latch_err(ERR_INVALID);
        else begin
          key_q[rq.cand_index][0] = rq.est_total_cycles;
          key_q[rq.cand_index][1] = rq.off_chip_bytes;
          key_q[rq.cand_index][2] = rq.dma_cycle_count;
          key_q[rq.cand_index][3] = rq.local_mem_cycles;
          key_q[rq.cand_index][4] = rq.compute_cycle_count;
          key_q[rq.cand_index][5] = rq.physical_mac_count;
          util_q[rq.cand_index] = rq.pe_util;
          seen_q[rq.cand_index] = 1'b1;
        end
      end
      default: begin
        nleg = 0; nill = 0; n = 0;
        for (int i = 0; i < cand_cnt; i++)
          if (legal_q[i]) nleg++; else nill++;
        code = ERR_OK;
        if (latched_err == ERR_OVERFLOW) code = ERR_OVERFLOW;
        else if (nleg == 0) code = ERR_NO_LEGAL;
        else if (latched_err != ERR_OK) code = latched_err;
        else
          for (int i = 0; i < cand_cnt; i++)
            if (legal_q[i] && !seen_q[i] && code == ERR_OK) code = ERR_MISSING;
        r = '0;
        r.legal_total = 5'(nleg);
        r.illegal_total = 5'(nill);
        if (code != ERR_OK) begin
          r.error_code = code;
          r.is_last = 1'b1;
          ranking_q = {ranking_q, r};
        end else begin
          for (int i = 0; i < cand_cnt; i++) begin
            if (!legal_q[i]) continue;
            j = n;
            while (j > 0 && ranks_ahead(i, order[j-1])) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i;
            n++;
          end
          r.decisive_key = KeyNone;
          w = key_q[order[0]][0];
          if (n >= 2) begin
            ru = key_q[order[1]][0];
            r.has_runner_up = 1'b1;
            r.cycle_advantage = (ru >= w) ? ru - w : '0;
            r.primary_tied = (ru == w);
            r.decisive_key = diff_key(order[0], order[1]);
          end
          for (int k = 0; k < n; k++) begin
            r.rank = 4'(k);
            r.original_index = 4'(order[k]);
            r.ranked_total_cycles = key_q[order[k]][0];
            r.is_selected = (k == 0);
            r.is_last = (k + 1 == n);
            ranking_q = {ranking_q, r};
          end
        end
        clear_table();
      end
    endcase
  endfunction

  // ---- result checker and watchdog ----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles <= (res_valid_o || (start_i && !busy_o)) ? 0 : idle_cycles + 1;
      if (res_valid_o) begin
        if (ranking_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res_o);
          errors++;
        end else begin
          res_t e;
          e = ranking_q.pop_front();
          if (res_o.error_code !== e.error_code ||
              res_o.rank !== e.rank ||
              res_o.original_index !== e.original_index ||
              res_o.ranked_total_cycles !== e.ranked_total_cycles ||
              res_o.is_selected !== e.is_selected ||
              res_o.is_last !== e.is_last ||
              res_o.legal_total !== e.legal_total ||
              res_o.illegal_total !== e.illegal_total ||
              res_o.has_runner_up !== e.has_runner_up ||
              res_o.cycle_advantage !== e.cycle_advantage ||
              res_o.primary_tied !== e.primary_tied ||
              res_o.decisive_key !== e.decisive_key) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, res_o);
            errors++;
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---- request driver ----
  // After an optional random gap with start_i low, presents the request at a
  // falling edge and holds it until the block takes it. The predictor runs on
  // the accepting edge. start_i stays high into the next cycle, where busy_o is always high.
  task automatic send_req(req_t rq);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i <= rq;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    rank_predict(rq);
    @(negedge clk_i);
  endtask

  function automatic req_t rec_req(bit legal);
    req_t rq;
    rq = '0;
    rq.opcode = legal ? OP_LEGAL : OP_ILLEGAL;
    rq.cand_index = 8'($urandom);
    return rq;
  endfunction

  // valid estimate; with narrow set, keys come from a narrow range so ties happen often
  function automatic req_t cost_req(int idx, bit narrow);
    req_t rq;
    rq.opcode = OP_COST;
    rq.cand_index = 8'(idx);
    if (narrow) begin
      rq.est_total_cycles = 48'($urandom_range(0, 3));
      rq.off_chip_bytes = 48'($urandom_range(0, 2));
      rq.dma_cycle_count = 48'($urandom_range(0, 1));
      rq.local_mem_cycles = 48'($urandom_range(0, 1));
      rq.compute_cycle_count = 48'($urandom_range(1, 2));
      rq.physical_mac_count = 48'($urandom_range(0, 1));
      rq.pe_util = 17'($urandom_range(65535, 65536));
    end else begin
      rq.est_total_cycles = 48'({$urandom, $urandom});
      rq.off_chip_bytes = 48'({$urandom, $urandom});
      rq.dma_cycle_count = 48'({$urandom, $urandom});
      rq.local_mem_cycles = 48'({$urandom, $urandom});
      rq.compute_cycle_count = 48'({$urandom, $urandom}) | 48'd1;
      rq.physical_mac_count = 48'({$urandom, $urandom});
      rq.pe_util = 17'($urandom_range(0, 65536));
    end
    rq.tile_total = 24'($urandom_range(1, 24'hFF_FFFF));
    rq.tiles_m = 24'($urandom_range(1, 24'hFF_FFFF));
    rq.tiles_n = 24'($urandom_range(1, 24'hFF_FFFF));
    return rq;
  endfunction

  function automatic req_t finish_req();
    req_t rq;
    rq = cost_req(0, 1'b0);
    rq.opcode = OP_FINISH;
    rq.cand_index = 8'($urandom);
    return rq;
  endfunction

  // ---- tests ----
  task automatic test_extremes();
    req_t rq;
    send_req(rec_req(1'b1));
    send_req(rec_req(1'b1));
    send_req(rec_req(1'b0));
    rq = cost_req(0, 1'b0);
    rq.est_total_cycles = KeyMax; rq.off_chip_bytes = KeyMax;
    rq.dma_cycle_count = KeyMax; rq.local_mem_cycles = KeyMax;
    rq.compute_cycle_count = KeyMax; rq.physical_mac_count = KeyMax;
    rq.pe_util = UtilOne; rq.tile_total = TileMax; rq.tiles_m = TileMax;
    rq.tiles_n = TileMax;
    send_req(rq);
    rq = cost_req(1, 1'b0);
    rq.est_total_cycles = '0; rq.off_chip_bytes = '0;
    rq.dma_cycle_count = '0; rq.local_mem_cycles = '0;
    rq.compute_cycle_count = 48'd1; rq.physical_mac_count = '0;
    rq.pe_util = '0; rq.tile_total = 24'd1; rq.tiles_m = 24'd1; rq.tiles_n = 24'd1;
    send_req(rq);
    send_req(finish_req());
  endtask

  task automatic test_errors();
    req_t rq;
    // no legal candidate at all
    send_req(finish_req());
    // unknown index
    send_req(rec_req(1'b1));
    send_req(cost_req(200, 1'b0));
    send_req(finish_req());
    // estimate for an illegal candidate
    send_req(rec_req(1'b0)); send_req(rec_req(1'b1));
    send_req(cost_req(0, 1'b0));
    send_req(finish_req());
    // duplicate estimate
    send_req(rec_req(1'b1));
    send_req(cost_req(0, 1'b1)); send_req(cost_req(0, 1'b1));
    send_req(finish_req());
    // utilization above one
    send_req(rec_req(1'b1));
    rq = cost_req(0, 1'b0); rq.pe_util = 17'h1FFFF; send_req(rq);
    send_req(finish_req());
    // zero tile count
    send_req(rec_req(1'b1));
    rq = cost_req(0, 1'b0); rq.tiles_m = '0; send_req(rq);
    send_req(finish_req());
    // missing estimate
    send_req(rec_req(1'b1)); send_req(rec_req(1'b1));
    send_req(cost_req(1, 1'b0));
    send_req(finish_req());
  endtask

  task automatic test_overflow();
    for (int i = 0; i < NCand + 1; i++) send_req(rec_req(1'b1));
    send_req(finish_req());
  endtask

  // Mostly well-formed batches with random content; some broken ones.
  task automatic test_random(int unsigned n_items);
    int unsigned sent, n, pick, perm [NCand];
    bit narrow;
    req_t rq;
    sent = 0;
    while (sent < n_items) begin
      // most batches small, a few full
      n = ($urandom_range(0, 7) == 0) ? NCand : $urandom_range(1, 5);
      narrow = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
        send_req(rec_req($urandom_range(0, 4) != 0));
        perm[i] = i;
      end
      for (int i = n - 1; i > 0; i--) begin
        pick = $urandom_range(0, i);
        {perm[i], perm[pick]} = {perm[pick], perm[i]};
      end
      for (int i = 0; i < n; i++) begin
        if (!legal_q[perm[i]] && $urandom_range(0, 7) != 0) continue;
        rq = cost_req(perm[i], narrow);
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 6))
            0: rq.pe_util = 17'($urandom_range(65537, 131071));
            1: rq.tile_total = '0;
            2: rq.tiles_n = '0;
            3: rq.compute_cycle_count = '0;
            4: rq.cand_index = 8'($urandom);
            default: rq.cand_index = 8'(perm[0]);
          endcase
        end
        if ($urandom_range(0, 15) != 0) begin
          send_req(rq);
          sent++;
        end
      end
      if ($urandom_range(0, 15) == 0) send_req(rec_req(1'($urandom_range(0, 1))));
      send_req(finish_req());
      sent += n + 1;
    end
  endtask

  initial begin
    clear_table();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_errors();
    test_overflow();
    test_random(280);
    start_i <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && ranking_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/vmkcr_pkg.sv
rtl/core/vmkcr_ctrl.sv
rtl/core/vmkcr_datapath.sv
rtl/core/validated_multi_key_candidate_ranker.sv
bench/validated_multi_key_candidate_ranker_test.sv
